// File: rtl/core/ffha_pkg.sv
// Shared constants and codes of the first-fit heap allocator.
package ffha_pkg;

    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int SIZE_W           = 16;
    localparam int UNITS_W          = 17;
    localparam int UNIT_SHIFT       = 4;
    localparam int HEADER_UNITS     = 2;
    localparam int RESET_HEAP_UNITS = 4096;
    localparam int MAX_HEAP_UNITS   = 65536;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ALLOC_FAIL = 2'd1,
        ST_BAD_FREE   = 2'd2
    } t_status;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

endpackage

// File: rtl/core/ffha_table.sv
// Block table memory: one write port and one registered read port.
module ffha_table #(
    parameter int DEPTH = ffha_pkg::DEF_MAX_BLOCKS,
    parameter int AW    = $clog2(ffha_pkg::DEF_MAX_BLOCKS),
    parameter int DW    = 23
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator: sequencer, flags and block table.
//
// Usage. A request is presented on i_operation, i_request_bytes and i_address
// and is taken at a rising edge where start is high and busy is low. An
// allocate rounds the size up to 16-byte units and walks the block chain in
// address order to the first free block that fits, splitting it when at
// least three units are left over and a table slot is spare. A free walks
// the chain to the block whose payload offset matches and then makes one
// merging pass over the chain, joining neighbouring free blocks.
// Each request that is not cut short by a write of heap_units gives exactly
// one result on o_status, o_payload_offset and o_free_bytes, shown for one
// cycle with o_valid high; the receiver cannot stall, so the result must be
// taken in that cycle.
// The walk reads the chain one table entry at a time through the single
// read port of the block table; an allocate first searches for a spare
// slot, and a free ends with a merging pass over the chain. busy stays high
// throughout a walk; an allocate of zero bytes is answered in the cycle after
// it is taken without busy going high. After reset, and after any write of
// heap_units over the APB port, the heap is rebuilt as one free block, if it
// holds at least HEADER_UNITS, while busy is high.
module first_fit_heap_allocator_unit #(
    parameter int MAX_BLOCKS = ffha_pkg::DEF_MAX_BLOCKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [19:0] i_request_bytes,
    input  logic [19:0] i_address,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [19:0] o_payload_offset,
    output logic [20:0] o_free_bytes
);

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
    localparam int SW     = ffha_pkg::SIZE_W;
    localparam int UW     = ffha_pkg::UNITS_W;
    localparam int ENT_W  = LINK_W + SW;
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_BLOCKS);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_INIT = 9'b000000010,
        S_SCAN = 9'b000000100,
        S_WRD  = 9'b000001000,
        S_WEV  = 9'b000010000,
        S_SPL2 = 9'b000100000,
        S_MST  = 9'b001000000,
        S_MRD  = 9'b010000000,
        S_MEV  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic              r_op, n_op;
    logic [UW-1:0]     r_units, n_units;
    logic [19:0]       r_addr, n_addr;
    logic [LINK_W-1:0] r_s, n_s;
    logic [17:0]       r_off, n_off;
    logic [LINK_W-1:0] r_n, n_n;
    logic [LINK_W-1:0] r_cur, n_cur;
    logic [SW-1:0]     r_cur_size, n_cur_size;
    logic [LINK_W-1:0] r_cur_link, n_cur_link;
    logic [ENT_W-1:0]  r_aux, n_aux;
    logic [UW-1:0]     r_free_units, n_free_units;
    logic [MAX_BLOCKS-1:0] r_in_use, n_in_use;
    logic [MAX_BLOCKS-1:0] r_is_free, n_is_free;
    logic              r_valid, n_valid;
    logic [1:0]        r_status, n_status;
    logic [19:0]       r_offset, n_offset;
    logic [UW-1:0]     r_free_out, n_free_out;
    logic [UW-1:0]     r_heap_units, n_heap_units;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    logic [ENT_W-1:0]  mem_wdata, mem_rdata;

    logic [SW-1:0]     rd_size;
    logic [LINK_W-1:0] rd_link;
    logic              s_live, link_live, nx_live;
    logic [UW-1:0]     heap_clamped;
    logic [UW:0]       sz_ext;
    logic [21:0]       off_bytes;
    logic [20:0]       req_round;
    logic              cfg_wr;

    assign rd_size = mem_rdata[SW-1:0];
    assign rd_link = mem_rdata[ENT_W-1:SW];

    assign s_live    = (r_s < LINK_NULL) && r_in_use[r_s[IDX_W-1:0]];
    assign link_live = (r_cur_link < LINK_NULL) && r_in_use[r_cur_link[IDX_W-1:0]];
    assign nx_live   = (r_n < LINK_NULL);

    assign heap_clamped = (r_heap_units > UW'(ffha_pkg::MAX_HEAP_UNITS - 1)) ?
                          UW'(ffha_pkg::MAX_HEAP_UNITS) : r_heap_units;
    assign sz_ext    = {2'b00, rd_size};
    assign off_bytes = ({4'b0000, r_off} + 22'(ffha_pkg::HEADER_UNITS)) << ffha_pkg::UNIT_SHIFT;
    assign req_round = {1'b0, i_request_bytes} + 21'd15;
    assign cfg_wr    = psel && penable && pwrite && pready;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_units      = r_units;
        n_addr       = r_addr;
        n_s          = r_s;
        n_off        = r_off;
        n_n          = r_n;
        n_cur        = r_cur;
        n_cur_size   = r_cur_size;
        n_cur_link   = r_cur_link;
        n_aux        = r_aux;
        n_free_units = r_free_units;
        n_in_use     = r_in_use;
        n_is_free    = r_is_free;
        n_valid      = 1'b0;
        n_status     = r_status;
        n_offset     = r_offset;
        n_free_out   = r_free_out;
        n_heap_units = r_heap_units;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = r_s[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_operation;
                    n_units = req_round[UW+3:4];
                    n_addr  = i_address;
                    n_s     = '0;
                    n_off   = '0;
                    n_n     = '0;
                    if (i_operation == ffha_pkg::OP_FREE) begin
                        n_state = S_WRD;
                    end else if (i_request_bytes == '0) begin
                        n_valid  = 1'b1;
                        n_status = ffha_pkg::ST_ALLOC_FAIL;
                        n_offset = '0;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_INIT: begin
                n_in_use  = '0;
                n_is_free = '0;
                n_free_units = '0;
                if (heap_clamped >= UW'(ffha_pkg::HEADER_UNITS)) begin
                    n_in_use[0]  = 1'b1;
                    n_is_free[0] = 1'b1;
                    n_free_units = heap_clamped - UW'(ffha_pkg::HEADER_UNITS);
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = {LINK_NULL, n_free_units[SW-1:0]};
                end
                n_state = S_IDLE;
            end
            S_SCAN: begin
                // Find the lowest spare table slot, one slot a cycle.
                if (r_n == LINK_NULL || !r_in_use[r_n[IDX_W-1:0]]) begin
                    n_state = S_WRD;
                end else begin
                    n_n = r_n + 1'b1;
                end
            end
            S_WRD: begin
                if (s_live) begin
                    n_state = S_WEV;
                end else begin
                    n_valid  = 1'b1;
                    n_status = (r_op == ffha_pkg::OP_FREE) ?
                               ffha_pkg::ST_BAD_FREE : ffha_pkg::ST_ALLOC_FAIL;
                    n_offset = '0;
                    n_state  = S_IDLE;
                end
            end
            S_WEV: begin
                if (r_op == ffha_pkg::OP_ALLOC) begin
                    if (r_is_free[r_s[IDX_W-1:0]] && sz_ext >= {1'b0, r_units}) begin
                        n_is_free[r_s[IDX_W-1:0]] = 1'b0;
                        n_status = ffha_pkg::ST_OK;
                        n_offset = off_bytes[19:0];
                        if (sz_ext >= {1'b0, r_units} + 18'(ffha_pkg::HEADER_UNITS + 1)
                            && nx_live) begin
                            n_in_use[r_n[IDX_W-1:0]]  = 1'b1;
                            n_is_free[r_n[IDX_W-1:0]] = 1'b1;
                            mem_we    = 1'b1;
                            mem_waddr = r_s[IDX_W-1:0];
                            mem_wdata = {r_n, r_units[SW-1:0]};
                            n_aux     = {rd_link, 16'(sz_ext - {1'b0, r_units}
                                         - 18'(ffha_pkg::HEADER_UNITS))};
                            n_free_units = r_free_units - r_units
                                           - UW'(ffha_pkg::HEADER_UNITS);
                            n_state = S_SPL2;
                        end else begin
                            n_free_units = r_free_units - UW'(rd_size);
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_off   = r_off + 18'(ffha_pkg::HEADER_UNITS) + 18'(rd_size);
                        n_s     = rd_link;
                        n_state = S_WRD;
                    end
                end else begin
                    if (off_bytes == {2'b00, r_addr}) begin
                        if (!r_is_free[r_s[IDX_W-1:0]]) begin
                            n_free_units = r_free_units + UW'(rd_size);
                        end
                        n_is_free[r_s[IDX_W-1:0]] = 1'b1;
                        n_state = S_MST;
                    end else begin
                        n_off   = r_off + 18'(ffha_pkg::HEADER_UNITS) + 18'(rd_size);
                        n_s     = rd_link;
                        n_state = S_WRD;
                    end
                end
            end
            S_SPL2: begin
                mem_we    = 1'b1;
                mem_waddr = r_n[IDX_W-1:0];
                mem_wdata = r_aux;
                n_valid   = 1'b1;
                n_state   = S_IDLE;
            end
            S_MST: begin
                mem_raddr = '0;
                n_cur     = '0;
                n_state   = S_MRD;
                n_cur_size = r_cur_size;
                // Head entry arrives next cycle; flag it by a null link for now.
                n_cur_link = LINK_NULL;
                n_s        = LINK_NULL;
            end
            S_MRD: begin
                if (r_s == LINK_NULL) begin
                    // First pass: take the head entry from the read port.
                    n_cur_size = rd_size;
                    n_cur_link = rd_link;
                    n_s        = '0;
                    mem_raddr  = rd_link[IDX_W-1:0];
                    if ((rd_link < LINK_NULL) && r_in_use[rd_link[IDX_W-1:0]]) begin
                        n_state = S_MEV;
                    end else begin
                        n_valid  = 1'b1;
                        n_status = ffha_pkg::ST_OK;
                        n_offset = '0;
                        n_state  = S_IDLE;
                    end
                end else begin
                    mem_raddr = r_cur_link[IDX_W-1:0];
                    if (link_live) begin
                        n_state = S_MEV;
                    end else begin
                        n_valid  = 1'b1;
                        n_status = ffha_pkg::ST_OK;
                        n_offset = '0;
                        n_state  = S_IDLE;
                    end
                end
            end
            S_MEV: begin
                if (r_is_free[r_cur[IDX_W-1:0]] && r_is_free[r_cur_link[IDX_W-1:0]]) begin
                    n_cur_size = r_cur_size + SW'(ffha_pkg::HEADER_UNITS) + rd_size;
                    n_cur_link = rd_link;
                    n_in_use[r_cur_link[IDX_W-1:0]]  = 1'b0;
                    n_is_free[r_cur_link[IDX_W-1:0]] = 1'b0;
                    n_free_units = r_free_units + UW'(ffha_pkg::HEADER_UNITS);
                    mem_we    = 1'b1;
                    mem_waddr = r_cur[IDX_W-1:0];
                    mem_wdata = {rd_link, n_cur_size};
                end else begin
                    n_cur      = r_cur_link;
                    n_cur_size = rd_size;
                    n_cur_link = rd_link;
                end
                n_state = S_MRD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (n_valid) begin
            n_free_out = n_free_units;
        end

        if (cfg_wr && !paddr[2]) begin
            n_heap_units = pwdata[UW-1:0];
            n_state      = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_heap_units <= UW'(ffha_pkg::RESET_HEAP_UNITS);
            r_in_use     <= '0;
            r_is_free    <= '0;
            r_free_units <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_heap_units <= n_heap_units;
            r_in_use     <= n_in_use;
            r_is_free    <= n_is_free;
            r_free_units <= n_free_units;
            r_valid      <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_units    <= n_units;
        r_addr     <= n_addr;
        r_s        <= n_s;
        r_off      <= n_off;
        r_n        <= n_n;
        r_cur      <= n_cur;
        r_cur_size <= n_cur_size;
        r_cur_link <= n_cur_link;
        r_aux      <= n_aux;
        r_status   <= n_status;
        r_offset   <= n_offset;
        r_free_out <= n_free_out;
    end

    ffha_table #(
        .DEPTH (MAX_BLOCKS),
        .AW    (IDX_W),
        .DW    (ENT_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign busy             = (r_state != S_IDLE);
    assign pready           = 1'b1;
    assign prdata           = paddr[2] ? 32'd0 : {{(32 - UW){1'b0}}, r_heap_units};
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_payload_offset = r_offset;
    assign o_free_bytes     = {r_free_out, 4'b0000};

    // A failed or free result never carries an offset.
    a_fail_zero_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ffha_pkg::ST_OK) |-> (o_payload_offset == '0))
        else $error("failed request returned an offset");

    // An accepted request that needs a walk keeps the block busy in the next cycle.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy
         && !(i_operation == ffha_pkg::OP_ALLOC && i_request_bytes == '0)) |=> busy)
        else $error("request accepted without going busy");

    // Free payload never exceeds the largest possible heap.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_units <= UW'(ffha_pkg::MAX_HEAP_UNITS - ffha_pkg::HEADER_UNITS))
        else $error("free unit count out of range");

    // A result only appears on the cycle after the sequencer was busy or start was high.
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy) || $past(start))
        else $error("result without a request");

endmodule
